// ===== sv/bsc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the barometer sample compensation block.
// Depends on nothing; every other file of the block imports it.
package bsc_pkg;

   // Divisor magnitude width: the divisor is a 64-bit value shifted right by 33.
   localparam int DEN_W      = 31;
   // One quotient bit is resolved per divider stage.
   localparam int DIV_STAGES = 64;

   localparam logic [32:0] TEMP_OFFSET = 33'd128000;
   localparam logic [20:0] PRESS_BASE  = 21'd1048576;
   localparam logic [11:0] PRESS_SCALE = 12'd3125;
   localparam logic [63:0] CAL_BIAS    = 64'h0000_8000_0000_0000;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_TEMP_CAL   = 2'd0,
      CSR_PRESS_LOW  = 2'd1,
      CSR_PRESS_MID  = 2'd2,
      CSR_PRESS_HIGH = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [19:0] raw_temperature;
      logic [19:0] raw_pressure;
   } bsc_req_type;

   typedef struct packed {
      logic signed [31:0] temperature_centi;
      logic signed [31:0] fine_temperature;
      logic [31:0]        pressure_q24_8;
      logic               divisor_zero;
   } bsc_rsp_type;

   // Calibration words unpacked from the configuration registers.
   typedef struct packed {
      logic [15:0]        t1;
      logic signed [15:0] t2;
      logic signed [15:0] t3;
      logic [15:0]        p1;
      logic signed [15:0] p2;
      logic signed [15:0] p3;
      logic signed [15:0] p4;
      logic signed [15:0] p5;
      logic signed [15:0] p6;
      logic signed [15:0] p7;
      logic signed [15:0] p8;
      logic signed [15:0] p9;
   } bsc_cal_type;

   // Temperature section to pressure section.
   typedef struct packed {
      logic               valid;
      logic signed [31:0] centi;
      logic signed [31:0] fine;
      logic signed [32:0] v1;
      logic [19:0]        adc_p;
   } bsc_tmp_type;

   // Pressure set-up section to divider.
   typedef struct packed {
      logic               valid;
      logic signed [31:0] centi;
      logic signed [31:0] fine;
      logic [63:0]        num;
      logic [DEN_W-1:0]   den;
   } bsc_pre_type;

   // One divider stage; nq holds the remaining dividend bits and the quotient bits so far.
   typedef struct packed {
      logic               valid;
      logic signed [31:0] centi;
      logic signed [31:0] fine;
      logic               zero;
      logic               neg;
      logic [DEN_W-1:0]   dmag;
      logic [DEN_W-1:0]   rem;
      logic [63:0]        nq;
   } bsc_div_type;

   // Low partial product of a 32-bit slice and a signed 16-bit word, exact.
   function automatic logic signed [48:0] mul_lo_part(logic [31:0] a, logic signed [15:0] c);
      return $signed({1'b0, a}) * c;
   endfunction

   // High slice times a signed 16-bit word; only the low 32 bits matter.
   function automatic logic [31:0] mul_hi_part(logic [31:0] a, logic signed [15:0] c);
      logic [31:0] cx;
      cx = {{16{c[15]}}, c};
      return a * cx;
   endfunction

   // Join the two partial products into the low 64 bits of the full product.
   function automatic logic [63:0] join_part(logic signed [48:0] lo, logic [31:0] hi);
      return {{15{lo[48]}}, lo} + {hi, 32'd0};
   endfunction

endpackage

// ===== sv/barometer_sample_compensation_top.sv =====
`timescale 1ns / 1ps
// Top level of the barometer sample compensation block: configuration registers,
// flow control and the four pipeline sections. Uses bsc_pkg and the bsc_* modules.

// The block takes one word per clock cycle and gives each result in order, after
// 5 stages of temperature math, 7 stages that build the pressure dividend and divisor,
// a 65-stage divider (a sign and magnitude stage, then one quotient bit per stage) and
// 6 stages of pressure correction ending in the output register. The whole pipeline
// holds while a result waits on rsp_ready, so req_ready is low exactly when a result is
// waiting and not being taken. Calibration registers are written through the csr_ port
// and must only change while no word is in flight.
module barometer_sample_compensation_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  bsc_pkg::bsc_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output bsc_pkg::bsc_rsp_type rsp_data,
   input  logic                 csr_wr_en,
   input  logic [1:0]           csr_index,
   input  logic [63:0]          csr_wr_data
);
   import bsc_pkg::*;

   logic [47:0] temp_cal_ff;
   logic [63:0] press_low_ff;
   logic [63:0] press_mid_ff;
   logic [15:0] press_high_ff;
   bsc_cal_type cal;
   logic        adv;
   bsc_tmp_type tmp_s;
   bsc_pre_type pre_s;
   bsc_div_type div_s;

   // Configuration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         temp_cal_ff   <= '0;
         press_low_ff  <= '0;
         press_mid_ff  <= '0;
         press_high_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TEMP_CAL:   temp_cal_ff   <= csr_wr_data[47:0];
            CSR_PRESS_LOW:  press_low_ff  <= csr_wr_data;
            CSR_PRESS_MID:  press_mid_ff  <= csr_wr_data;
            CSR_PRESS_HIGH: press_high_ff <= csr_wr_data[15:0];
            default: ;
         endcase
      end
   end

   // Unpack the calibration words.
   always_comb begin
      cal.t1 = temp_cal_ff[15:0];
      cal.t2 = temp_cal_ff[31:16];
      cal.t3 = temp_cal_ff[47:32];
      cal.p1 = press_low_ff[15:0];
      cal.p2 = press_low_ff[31:16];
      cal.p3 = press_low_ff[47:32];
      cal.p4 = press_low_ff[63:48];
      cal.p5 = press_mid_ff[15:0];
      cal.p6 = press_mid_ff[31:16];
      cal.p7 = press_mid_ff[47:32];
      cal.p8 = press_mid_ff[63:48];
      cal.p9 = press_high_ff;
   end

   // The pipeline moves whenever the output register is empty or being read.
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   bsc_temp u_temp (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .up_valid (req_valid),
      .up_data  (req_data),
      .cal      (cal),
      .dn       (tmp_s)
   );

   bsc_pre u_pre (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .up    (tmp_s),
      .cal   (cal),
      .dn    (pre_s)
   );

   bsc_div u_div (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .up    (pre_s),
      .dn    (div_s)
   );

   bsc_post u_post (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .up       (div_s),
      .cal      (cal),
      .dn_valid (rsp_valid),
      .dn_data  (rsp_data)
   );

endmodule

// ===== sv/bsc_temp.sv =====
`timescale 1ns / 1ps
// Temperature section: five register stages that form the fine temperature,
// the temperature in hundredths of a degree and the pressure offset term. Uses bsc_pkg.
module bsc_temp (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 up_valid,
   input  bsc_pkg::bsc_req_type up_data,
   input  bsc_pkg::bsc_cal_type cal,
   output bsc_pkg::bsc_tmp_type dn
);
   import bsc_pkg::*;

   logic               s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   logic signed [17:0] s1_x_ff;
   logic signed [16:0] s1_d_ff;
   logic [19:0]        s1_adc_p_ff, s2_adc_p_ff, s3_adc_p_ff, s4_adc_p_ff, s5_adc_p_ff;
   logic signed [33:0] xa_full, dd_full;
   logic [31:0]        s2_xa_ff, s2_dd_ff;
   logic signed [35:0] bp_full;
   logic [31:0]        s3_a_ff, s3_bp_ff;
   logic [31:0]        s4_fine_ff;
   logic [31:0]        c5_in;
   logic [31:0]        s5_centi_ff, s5_fine_ff;
   logic [32:0]        s5_v1_ff;

   // Valid bits follow the words through the stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= up_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   // Stage 1: the two differences against T1.
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_x_ff     <= $signed({1'b0, up_data.raw_temperature[19:3]})
                        - $signed({1'b0, cal.t1, 1'b0});
         s1_d_ff     <= $signed({1'b0, up_data.raw_temperature[19:4]})
                        - $signed({1'b0, cal.t1});
         s1_adc_p_ff <= up_data.raw_pressure;
      end
   end

   // Stage 2: linear and square products, wrapped to 32 bits.
   assign xa_full = s1_x_ff * cal.t2;
   assign dd_full = s1_d_ff * s1_d_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_xa_ff    <= xa_full[31:0];
         s2_dd_ff    <= dd_full[31:0];
         s2_adc_p_ff <= s1_adc_p_ff;
      end
   end

   // Stage 3: scale the linear term and multiply the square term by T3.
   assign bp_full = $signed(s2_dd_ff[31:12]) * cal.t3;

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_a_ff     <= $signed(s2_xa_ff) >>> 11;
         s3_bp_ff    <= bp_full[31:0];
         s3_adc_p_ff <= s2_adc_p_ff;
      end
   end

   // Stage 4: the fine temperature.
   always_ff @(posedge clock) begin
      if (adv) begin
         s4_fine_ff  <= s3_a_ff + 32'($signed(s3_bp_ff) >>> 14);
         s4_adc_p_ff <= s3_adc_p_ff;
      end
   end

   // Stage 5: rounded temperature and the signed offset for the pressure formula.
   assign c5_in = s4_fine_ff + {s4_fine_ff[29:0], 2'd0} + 32'd128;

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_centi_ff <= $signed(c5_in) >>> 8;
         s5_fine_ff  <= s4_fine_ff;
         s5_v1_ff    <= {s4_fine_ff[31], s4_fine_ff} - TEMP_OFFSET;
         s5_adc_p_ff <= s4_adc_p_ff;
      end
   end

   assign dn.valid = s5_valid_ff;
   assign dn.centi = s5_centi_ff;
   assign dn.fine  = s5_fine_ff;
   assign dn.v1    = s5_v1_ff;
   assign dn.adc_p = s5_adc_p_ff;

endmodule

// ===== sv/bsc_pre.sv =====
`timescale 1ns / 1ps
// Pressure set-up section: seven register stages that build the 64-bit dividend and
// the divisor from the offset term, the raw pressure and P1 to P6. Uses bsc_pkg.
module bsc_pre (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  bsc_pkg::bsc_tmp_type up,
   input  bsc_pkg::bsc_cal_type cal,
   output bsc_pkg::bsc_pre_type dn
);
   import bsc_pkg::*;

   logic [6:0]         valid_ff;
   logic [31:0]        centi_ff [0:6];
   logic [31:0]        fine_ff  [0:6];
   logic [19:0]        adc_p_ff [0:3];

   logic [32:0]        v1_neg;
   logic [31:0]        p1_av_ff;
   logic signed [48:0] p1_m5_ff, p1_m2_ff, p2_m5_ff, p2_m2_ff, p3_m5_ff, p3_m2_ff, p4_m2_ff;
   logic [63:0]        p2_sq_ff;
   logic signed [48:0] p3_q6l_ff, p3_q3l_ff;
   logic [31:0]        p3_q6h_ff, p3_q3h_ff;
   logic [63:0]        p4_v2_ff, p4_w_ff;
   logic [20:0]        base_diff;
   logic [63:0]        p5_y_ff, p5_t_ff;
   logic [47:0]        p6_yl_ff;
   logic [31:0]        p6_yh_ff;
   logic [43:0]        p6_nl_ff;
   logic [31:0]        p6_nh_ff;
   logic [63:0]        z_in;
   logic [63:0]        p7_num_ff;
   logic [DEN_W-1:0]   p7_den_ff;

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[5:0], up.valid};
      end
   end

   // Temperature results ride along to the divider.
   always_ff @(posedge clock) begin
      if (adv) begin
         centi_ff[0] <= up.centi;
         fine_ff[0]  <= up.fine;
         adc_p_ff[0] <= up.adc_p;
         for (int i = 1; i < 7; i++) begin
            centi_ff[i] <= centi_ff[i-1];
            fine_ff[i]  <= fine_ff[i-1];
         end
         for (int i = 1; i < 4; i++) begin
            adc_p_ff[i] <= adc_p_ff[i-1];
         end
      end
   end

   assign v1_neg = -up.v1;

   // Stages 1 to 3: magnitude, square, and the products with P2, P3, P5 and P6.
   always_ff @(posedge clock) begin
      if (adv) begin
         p1_av_ff  <= up.v1[32] ? v1_neg[31:0] : up.v1[31:0];
         p1_m5_ff  <= up.v1 * cal.p5;
         p1_m2_ff  <= up.v1 * cal.p2;
         p2_sq_ff  <= p1_av_ff * p1_av_ff;
         p2_m5_ff  <= p1_m5_ff;
         p2_m2_ff  <= p1_m2_ff;
         p3_q6l_ff <= mul_lo_part(p2_sq_ff[31:0], cal.p6);
         p3_q6h_ff <= mul_hi_part(p2_sq_ff[63:32], cal.p6);
         p3_q3l_ff <= mul_lo_part(p2_sq_ff[31:0], cal.p3);
         p3_q3h_ff <= mul_hi_part(p2_sq_ff[63:32], cal.p3);
         p3_m5_ff  <= p2_m5_ff;
         p3_m2_ff  <= p2_m2_ff;
      end
   end

   // Stage 4: the subtrahend of the dividend and the square term of the divisor.
   always_ff @(posedge clock) begin
      if (adv) begin
         p4_v2_ff <= join_part(p3_q6l_ff, p3_q6h_ff) + {p3_m5_ff[46:0], 17'd0}
                     + {{13{cal.p4[15]}}, cal.p4, 35'd0};
         p4_w_ff  <= join_part(p3_q3l_ff, p3_q3h_ff);
         p4_m2_ff <= p3_m2_ff;
      end
   end

   // Stage 5: biased divisor term and the raw dividend.
   assign base_diff = PRESS_BASE - {1'b0, adc_p_ff[3]};

   always_ff @(posedge clock) begin
      if (adv) begin
         p5_y_ff <= CAL_BIAS + 64'($signed(p4_w_ff) >>> 8)
                    + {{3{p4_m2_ff[48]}}, p4_m2_ff, 12'd0};
         p5_t_ff <= {12'd0, base_diff, 31'd0} - p4_v2_ff;
      end
   end

   // Stage 6: partial products with P1 and with the scale constant.
   always_ff @(posedge clock) begin
      if (adv) begin
         p6_yl_ff <= p5_y_ff[31:0] * cal.p1;
         p6_yh_ff <= p5_y_ff[63:32] * {16'd0, cal.p1};
         p6_nl_ff <= p5_t_ff[31:0] * PRESS_SCALE;
         p6_nh_ff <= p5_t_ff[63:32] * {20'd0, PRESS_SCALE};
      end
   end

   // Stage 7: join the partial products; the divisor keeps its top 31 bits.
   assign z_in = {16'd0, p6_yl_ff} + {p6_yh_ff, 32'd0};

   always_ff @(posedge clock) begin
      if (adv) begin
         p7_den_ff <= z_in[63:33];
         p7_num_ff <= {20'd0, p6_nl_ff} + {p6_nh_ff, 32'd0};
      end
   end

   assign dn.valid = valid_ff[6];
   assign dn.centi = centi_ff[6];
   assign dn.fine  = fine_ff[6];
   assign dn.num   = p7_num_ff;
   assign dn.den   = p7_den_ff;

endmodule

// ===== sv/bsc_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider: a sign and magnitude stage, then one quotient bit per stage.
// Gives the unsigned quotient of the magnitudes with the sign and zero flags. Uses bsc_pkg.
module bsc_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  bsc_pkg::bsc_pre_type up,
   output bsc_pkg::bsc_div_type dn
);
   import bsc_pkg::*;

   bsc_div_type      stage_ff [0:DIV_STAGES];
   bsc_div_type      stage_in [0:DIV_STAGES];
   logic [63:0]      num_neg;
   logic [DEN_W-1:0] den_neg;

   assign num_neg = -up.num;
   assign den_neg = -up.den;

   // Entry stage: signs, magnitudes and the zero-divisor flag.
   always_comb begin
      stage_in[0].valid = up.valid;
      stage_in[0].centi = up.centi;
      stage_in[0].fine  = up.fine;
      stage_in[0].zero  = (up.den == '0);
      stage_in[0].neg   = up.num[63] ^ up.den[DEN_W-1];
      stage_in[0].dmag  = up.den[DEN_W-1] ? den_neg : up.den;
      stage_in[0].rem   = '0;
      stage_in[0].nq    = up.num[63] ? num_neg : up.num;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff[0] <= '0;
      end else if (adv) begin
         stage_ff[0] <= stage_in[0];
      end
   end

   // Each stage brings down one dividend bit and subtracts the divisor when it fits.
   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_step
      logic [DEN_W+1:0] trial;

      assign trial = {1'b0, stage_ff[g].rem, stage_ff[g].nq[63]}
                     - {2'b00, stage_ff[g].dmag};

      always_comb begin
         stage_in[g+1]     = stage_ff[g];
         stage_in[g+1].nq  = {stage_ff[g].nq[62:0], ~trial[DEN_W+1]};
         stage_in[g+1].rem = trial[DEN_W+1] ? {stage_ff[g].rem[DEN_W-2:0], stage_ff[g].nq[63]}
                                            : trial[DEN_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stage_ff[g+1] <= '0;
         end else if (adv) begin
            stage_ff[g+1] <= stage_in[g+1];
         end
      end
   end

   assign dn = stage_ff[DIV_STAGES];

endmodule

// ===== sv/bsc_post.sv =====
`timescale 1ns / 1ps
// Pressure finishing section: signs the quotient, applies the P7 to P9 corrections
// and holds the output register. Six register stages. Uses bsc_pkg.
module bsc_post (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  bsc_pkg::bsc_div_type up,
   input  bsc_pkg::bsc_cal_type cal,
   output logic                 dn_valid,
   output bsc_pkg::bsc_rsp_type dn_data
);
   import bsc_pkg::*;

   logic [5:0]         valid_ff;
   logic [31:0]        centi_ff [0:4];
   logic [31:0]        fine_ff  [0:4];
   logic [4:0]         zero_ff;

   logic [63:0]        q0_p_ff, q1_p_ff, q2_p_ff, q3_p_ff, q4_p_ff;
   logic [63:0]        h_in;
   logic [63:0]        q1_h_ff, q2_h_ff;
   logic signed [48:0] q1_al_ff, q1_bl_ff;
   logic [31:0]        q1_ah_ff, q1_bh_ff;
   logic [63:0]        q2_a_ff;
   logic [63:0]        q2_v2_ff, q3_v2_ff, q4_v2_ff;
   logic [63:0]        q3_ll_ff;
   logic [31:0]        q3_lh_ff, q3_hl_ff;
   logic [63:0]        x_in;
   logic [63:0]        q4_v1_ff;
   logic [63:0]        s_in;
   logic [31:0]        r_in;
   bsc_rsp_type        out_ff;

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[4:0], up.valid};
      end
   end

   // Temperature results and the zero flag ride along.
   always_ff @(posedge clock) begin
      if (adv) begin
         centi_ff[0] <= up.centi;
         fine_ff[0]  <= up.fine;
         zero_ff[0]  <= up.zero;
         for (int i = 1; i < 5; i++) begin
            centi_ff[i] <= centi_ff[i-1];
            fine_ff[i]  <= fine_ff[i-1];
            zero_ff[i]  <= zero_ff[i-1];
         end
      end
   end

   // Stage 1: apply the quotient sign.
   always_ff @(posedge clock) begin
      if (adv) begin
         q0_p_ff <= up.neg ? -up.nq : up.nq;
      end
   end

   // Stage 2: partial products with P9 and P8.
   assign h_in = $signed(q0_p_ff) >>> 13;

   always_ff @(posedge clock) begin
      if (adv) begin
         q1_h_ff  <= h_in;
         q1_p_ff  <= q0_p_ff;
         q1_al_ff <= mul_lo_part(h_in[31:0], cal.p9);
         q1_ah_ff <= mul_hi_part(h_in[63:32], cal.p9);
         q1_bl_ff <= mul_lo_part(q0_p_ff[31:0], cal.p8);
         q1_bh_ff <= mul_hi_part(q0_p_ff[63:32], cal.p8);
      end
   end

   // Stage 3: join the partial products.
   always_ff @(posedge clock) begin
      if (adv) begin
         q2_a_ff  <= join_part(q1_al_ff, q1_ah_ff);
         q2_v2_ff <= $signed(join_part(q1_bl_ff, q1_bh_ff)) >>> 19;
         q2_h_ff  <= q1_h_ff;
         q2_p_ff  <= q1_p_ff;
      end
   end

   // Stage 4: low 64 bits of the 64 by 64 product, as three 32 by 32 parts.
   always_ff @(posedge clock) begin
      if (adv) begin
         q3_ll_ff <= q2_a_ff[31:0] * q2_h_ff[31:0];
         q3_lh_ff <= q2_a_ff[31:0] * q2_h_ff[63:32];
         q3_hl_ff <= q2_a_ff[63:32] * q2_h_ff[31:0];
         q3_v2_ff <= q2_v2_ff;
         q3_p_ff  <= q2_p_ff;
      end
   end

   // Stage 5: the P9 correction.
   assign x_in = q3_ll_ff + {q3_lh_ff + q3_hl_ff, 32'd0};

   always_ff @(posedge clock) begin
      if (adv) begin
         q4_v1_ff <= $signed(x_in) >>> 25;
         q4_v2_ff <= q3_v2_ff;
         q4_p_ff  <= q3_p_ff;
      end
   end

   // Stage 6: final sum, scaling and the P7 offset into the output register.
   assign s_in = q4_p_ff + q4_v1_ff + q4_v2_ff;
   assign r_in = s_in[39:8] + {{12{cal.p7[15]}}, cal.p7, 4'd0};

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff.temperature_centi <= centi_ff[4];
         out_ff.fine_temperature  <= fine_ff[4];
         out_ff.pressure_q24_8    <= zero_ff[4] ? '0 : r_in;
         out_ff.divisor_zero      <= zero_ff[4];
      end
   end

   assign dn_valid = valid_ff[5];
   assign dn_data  = out_ff;

endmodule

// ===== sv/bsc_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the barometer sample compensation top level, and the bind
// that attaches them. Uses bsc_pkg.
module bsc_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input bsc_pkg::bsc_rsp_type rsp_data
);
   import bsc_pkg::*;

   logic [31:0] f5;
   logic [31:0] centi_chk;

   // Rounded temperature recomputed from the fine temperature.
   assign f5        = rsp_data.fine_temperature * 32'd5 + 32'd128;
   assign centi_chk = $signed(f5) >>> 8;

   // The input side stalls only while a result waits.
   a_ready_follows_output: assert property (@(posedge clock)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("req_ready does not follow the output register state");

   // Nothing comes out right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   // A zero divisor forces the pressure to zero.
   a_zero_pressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.divisor_zero |-> rsp_data.pressure_q24_8 == 32'd0)
      else $error("pressure not zero with divisor_zero set");

   // The two temperature fields agree.
   a_centi_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.temperature_centi == centi_chk)
      else $error("temperature_centi does not match fine_temperature");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

endmodule

bind barometer_sample_compensation_top bsc_checker u_bsc_checker (.*);
